### sv/two_axis_mean_stddev_accumulator_unit_defines.svh
// Assertion macros used by the RTL file of the accumulator unit.
`ifndef TWO_AXIS_MEAN_STDDEV_ACCUMULATOR_UNIT_DEFINES_SVH
`define TWO_AXIS_MEAN_STDDEV_ACCUMULATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TAMSA_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
	else $error("tamsa assertion failed");
`define TAMSA_NEVER(lbl, ck, rn, prop) \
	`TAMSA_ASSERT(lbl, ck, rn, !(prop))
`else
`define TAMSA_ASSERT(lbl, ck, rn, prop)
`define TAMSA_NEVER(lbl, ck, rn, prop)
`endif
`endif

### sv/tamsa_pkg.sv
`default_nettype none
package tamsa_pkg;
	localparam int ANGLE_W = 22;
	localparam int CNT_W   = 10;
	localparam int MEAN_W  = 25;
	localparam int SD_W    = 24;
	localparam int SUM_W   = 32;
	localparam int SQ_W    = 52;
	localparam int DEN_W   = 37;
	localparam int WIDE_W  = 64;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_STOP   = 2'd2;

	localparam logic [7:0] STAT_X    = 8'h31;
	localparam logic [7:0] STAT_Y    = 8'h32;
	localparam logic [7:0] STAT_BOTH = 8'h33;

	// Arc seconds to microradians scale, 4.84813681 as a ratio of integers.
	localparam logic [31:0] K_NUM    = 32'd484813681;
	localparam logic [31:0] K_DEN    = 32'd100000000;
	localparam logic [63:0] MEAN_POS = 64'd16777215;
	localparam logic [63:0] MEAN_NEG = 64'd16777216;
	localparam logic [63:0] SD_MAX   = 64'd16777215;

	typedef enum logic {
		MODE_DIV  = 1'b0,
		MODE_SQRT = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic               start;
		unit_mode_t         mode;
		logic [WIDE_W-1:0]  a;
		logic [DEN_W-1:0]   b;
	} unit_req_t;

	typedef struct packed {
		logic               done;
		logic [WIDE_W-1:0]  result;
	} unit_rsp_t;
endpackage
`default_nettype wire

### sv/tamsa_if.sv
`default_nettype none
interface tamsa_item_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             cmd;
	logic [7:0]                             status_code;
	logic signed [tamsa_pkg::ANGLE_W-1:0]   x_angle;
	logic signed [tamsa_pkg::ANGLE_W-1:0]   y_angle;
	modport source(output valid, cmd, status_code, x_angle, y_angle, input ready);
	modport sink(input valid, cmd, status_code, x_angle, y_angle, output ready);
endinterface

interface tamsa_result_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   running;
	logic                                   done_res;
	logic [tamsa_pkg::CNT_W-1:0]            x_valid_count;
	logic [tamsa_pkg::CNT_W-1:0]            y_valid_count;
	logic [tamsa_pkg::CNT_W-1:0]            x_invalid_count;
	logic [tamsa_pkg::CNT_W-1:0]            y_invalid_count;
	logic signed [tamsa_pkg::MEAN_W-1:0]    x_mean;
	logic signed [tamsa_pkg::MEAN_W-1:0]    y_mean;
	logic [tamsa_pkg::SD_W-1:0]             x_stddev;
	logic [tamsa_pkg::SD_W-1:0]             y_stddev;
	modport source(output valid, running, done_res, x_valid_count, y_valid_count,
		x_invalid_count, y_invalid_count, x_mean, y_mean, x_stddev, y_stddev,
		input ready);
	modport sink(input valid, running, done_res, x_valid_count, y_valid_count,
		x_invalid_count, y_invalid_count, x_mean, y_mean, x_stddev, y_stddev,
		output ready);
endinterface

interface tamsa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tamsa_pkg::CNT_W-1:0]    average_size;
	modport source(output valid, average_size, input ready);
	modport sink(input valid, average_size, output ready);
endinterface
`default_nettype wire

### sv/tamsa_sqdiv.sv
`default_nettype none
// Iterative divider and square root sharing one compare-subtract.
module tamsa_sqdiv (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tamsa_pkg::unit_req_t req,
	output tamsa_pkg::unit_rsp_t      rsp
);
	logic [tamsa_pkg::WIDE_W-1:0] a_q;
	logic [37:0]                  r_q;
	logic [31:0]                  root_q;
	logic [tamsa_pkg::DEN_W-1:0]  b_q;
	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	tamsa_pkg::unit_mode_t        mode_q;
	logic [37:0]                  sh;
	logic [37:0]                  opnd;
	logic [38:0]                  diff;
	logic                         fits;
	logic                         last;

	always_comb begin
		if (mode_q == tamsa_pkg::MODE_DIV) begin
			sh   = {r_q[36:0], a_q[63]};
			opnd = {1'b0, b_q};
		end else begin
			sh   = {r_q[35:0], a_q[63:62]};
			opnd = {4'b0, root_q, 2'b01};
		end
		diff = {1'b0, sh} - {1'b0, opnd};
		fits = !diff[38];
		last = (mode_q == tamsa_pkg::MODE_DIV) ? (cnt_q == 6'd63) : (cnt_q == 6'd31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= tamsa_pkg::MODE_DIV;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				mode_q <= req.mode;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			b_q    <= req.b;
			r_q    <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (fits)
				r_q <= diff[37:0];
			else
				r_q <= sh;
			if (mode_q == tamsa_pkg::MODE_DIV) begin
				a_q <= {a_q[62:0], fits};
			end else begin
				a_q    <= {a_q[61:0], 2'b00};
				root_q <= {root_q[30:0], fits};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (mode_q == tamsa_pkg::MODE_DIV) ? a_q : {32'b0, root_q};
endmodule
`default_nettype wire

### sv/two_axis_mean_stddev_accumulator_unit.sv
// A sample request that ends a run takes per axis two divisions and one square root
// in the shared unit, with setup steps in the sequencer between them.
// One request is worked at a time; the next is taken once the result is registered.
// Reset (arst_n low, asynchronous) clears sums, counters, held results and run flag,
// and sets average_size to 10.
`default_nettype none
`include "two_axis_mean_stddev_accumulator_unit_defines.svh"
module two_axis_mean_stddev_accumulator_unit #(
	parameter int MAX_RUN    = 1023,
	parameter int ANGLE_BITS = 22
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tamsa_item_if.sink    item,
	tamsa_result_if.source result,
	tamsa_cfg_if.sink     cfg
);
	// Counters saturate at the smaller of MAX_RUN and the counter range.
	localparam logic [tamsa_pkg::CNT_W-1:0] CNT_LIM =
		(MAX_RUN < 1023) ? tamsa_pkg::CNT_W'(MAX_RUN) : 10'd1023;
	// Angles are sign extended from ANGLE_BITS; wider settings read the port as unsigned.
	localparam int SIGN_BIT = (ANGLE_BITS <= tamsa_pkg::ANGLE_W) ? ANGLE_BITS - 1 : 21;
	localparam bit SEXT     = (ANGLE_BITS <= tamsa_pkg::ANGLE_W);

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_SQX   = 19'h00002,
		S_SQY   = 19'h00004,
		S_END   = 19'h00008,
		S_DEN   = 19'h00010,
		S_MEANM = 19'h00020,
		S_MEANA = 19'h00040,
		S_MDIV  = 19'h00080,
		S_MWAIT = 19'h00100,
		S_D1L   = 19'h00200,
		S_D1H   = 19'h00400,
		S_D2    = 19'h00800,
		S_SUB   = 19'h01000,
		S_SQRT  = 19'h02000,
		S_QWAIT = 19'h04000,
		S_SDA   = 19'h08000,
		S_SDIV  = 19'h10000,
		S_SWAIT = 19'h20000,
		S_DONE  = 19'h40000
	} state_t;

	state_t state_q;
	logic   axis_q;
	logic   run_q;
	logic   done_q;
	logic   ovalid_q;
	logic   xv_q, yv_q;
	logic [tamsa_pkg::CNT_W-1:0]   avg_q, scnt_q, xcnt_q, ycnt_q, xbad_q, ybad_q;
	logic [tamsa_pkg::SUM_W-1:0]   xsum_q, ysum_q;
	logic [tamsa_pkg::SQ_W-1:0]    xsq_q, ysq_q;
	logic signed [tamsa_pkg::MEAN_W-1:0] xmean_q, ymean_q;
	logic [tamsa_pkg::SD_W-1:0]    xsd_q, ysd_q;
	logic [tamsa_pkg::ANGLE_W-1:0] xmag_q, ymag_q;
	logic [tamsa_pkg::WIDE_W-1:0]  prod_q, acc_q;
	logic [tamsa_pkg::DEN_W-1:0]   den_q;

	logic o_running_q, o_done_q;
	logic [tamsa_pkg::CNT_W-1:0] o_xc_q, o_yc_q, o_xb_q, o_yb_q;
	logic signed [tamsa_pkg::MEAN_W-1:0] o_xm_q, o_ym_q;
	logic [tamsa_pkg::SD_W-1:0] o_xs_q, o_ys_q;

	logic signed [tamsa_pkg::ANGLE_W:0] xs, ys;
	logic [tamsa_pkg::ANGLE_W:0]  xabs, yabs;
	logic                         xvalid, yvalid;
	logic [tamsa_pkg::CNT_W-1:0]  n;
	logic [tamsa_pkg::SUM_W-1:0]  sum;
	logic [tamsa_pkg::SUM_W-1:0]  sum_mag;
	logic [tamsa_pkg::SQ_W-1:0]   sq;
	logic [31:0]                  mul_a, mul_b;
	logic                         accept;
	logic [tamsa_pkg::WIDE_W-1:0] q;
	logic signed [tamsa_pkg::MEAN_W-1:0] mean_sat;
	logic [tamsa_pkg::SD_W-1:0]   sd_sat;
	logic                         load_out;
	tamsa_pkg::unit_req_t         ureq;
	tamsa_pkg::unit_rsp_t         ursp;

	function automatic logic [tamsa_pkg::CNT_W-1:0] sat_inc(
		input logic [tamsa_pkg::CNT_W-1:0] c
	);
		return (c < CNT_LIM) ? c + 10'd1 : c;
	endfunction

	// Sign extension of the raw angles into one spare bit, their magnitudes and status decode.
	always_comb begin
		for (int i = 0; i < tamsa_pkg::ANGLE_W; i++) begin
			xs[i] = (i <= SIGN_BIT) ? item.x_angle[i] : item.x_angle[SIGN_BIT];
			ys[i] = (i <= SIGN_BIT) ? item.y_angle[i] : item.y_angle[SIGN_BIT];
		end
		xs[tamsa_pkg::ANGLE_W] = SEXT ? item.x_angle[SIGN_BIT] : 1'b0;
		ys[tamsa_pkg::ANGLE_W] = SEXT ? item.y_angle[SIGN_BIT] : 1'b0;
		xabs = xs[tamsa_pkg::ANGLE_W] ? 23'(-xs) : 23'(xs);
		yabs = ys[tamsa_pkg::ANGLE_W] ? 23'(-ys) : 23'(ys);
		xvalid = (item.status_code == tamsa_pkg::STAT_X) ||
		         (item.status_code == tamsa_pkg::STAT_BOTH);
		yvalid = (item.status_code == tamsa_pkg::STAT_Y) ||
		         (item.status_code == tamsa_pkg::STAT_BOTH);
	end

	// Operands of the axis being finished.
	always_comb begin
		n       = axis_q ? ycnt_q : xcnt_q;
		sum     = axis_q ? ysum_q : xsum_q;
		sq      = axis_q ? ysq_q : xsq_q;
		sum_mag = sum[31] ? 32'(-sum) : sum;
	end

	// The shared 32 by 32 multiplier; its product is registered every cycle and
	// each state reads what the state before it asked for.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQX: begin
				mul_a = {10'b0, xmag_q};
				mul_b = {10'b0, xmag_q};
			end
			S_SQY: begin
				mul_a = {10'b0, ymag_q};
				mul_b = {10'b0, ymag_q};
			end
			S_DEN: begin
				mul_a = {22'b0, n};
				mul_b = tamsa_pkg::K_DEN;
			end
			S_MEANM: begin
				mul_a = sum_mag;
				mul_b = tamsa_pkg::K_NUM;
			end
			S_D1L: begin
				mul_a = {22'b0, n};
				mul_b = {6'b0, sq[25:0]};
			end
			S_D1H: begin
				mul_a = {22'b0, n};
				mul_b = {6'b0, sq[51:26]};
			end
			S_D2: begin
				mul_a = sum_mag;
				mul_b = sum_mag;
			end
			S_QWAIT: begin
				mul_a = ursp.result[31:0];
				mul_b = tamsa_pkg::K_NUM;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Rounded quotients are clamped to the output ranges; the mean takes the sum's sign.
	always_comb begin
		q = ursp.result;
		if (sum[31])
			mean_sat = (q > tamsa_pkg::MEAN_NEG) ? 25'h1000000 : 25'(-q);
		else
			mean_sat = (q > tamsa_pkg::MEAN_POS) ? 25'h0FFFFFF : q[24:0];
		sd_sat = (q > tamsa_pkg::SD_MAX) ? 24'hFFFFFF : q[23:0];
	end

	always_comb begin
		ureq.start = (state_q == S_MDIV) || (state_q == S_SQRT) || (state_q == S_SDIV);
		ureq.mode  = (state_q == S_SQRT) ? tamsa_pkg::MODE_SQRT : tamsa_pkg::MODE_DIV;
		ureq.a     = acc_q;
		ureq.b     = den_q;
	end

	tamsa_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.rsp    (ursp)
	);

	assign accept   = item.valid && item.ready;
	assign load_out = (state_q == S_DONE) && (!ovalid_q || result.ready);

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a * mul_b);
		unique case (state_q)
			S_MEANM: den_q <= prod_q[tamsa_pkg::DEN_W-1:0];
			S_MEANA: acc_q <= prod_q + {28'b0, den_q[36:1]};
			S_D1H:   acc_q <= prod_q;
			S_D2:    acc_q <= acc_q + {prod_q[37:0], 26'b0};
			S_SUB:   acc_q <= (acc_q > prod_q) ? acc_q - prod_q : '0;
			S_SDA:   acc_q <= prod_q + {28'b0, den_q[36:1]};
			default: acc_q <= acc_q;
		endcase
		if (accept) begin
			xmag_q <= xabs[tamsa_pkg::ANGLE_W-1:0];
			ymag_q <= yabs[tamsa_pkg::ANGLE_W-1:0];
			xv_q   <= xvalid;
			yv_q   <= yvalid;
		end
		if (load_out) begin
			o_running_q <= run_q;
			o_done_q    <= done_q;
			o_xc_q      <= xcnt_q;
			o_yc_q      <= ycnt_q;
			o_xb_q      <= xbad_q;
			o_yb_q      <= ybad_q;
			o_xm_q      <= xmean_q;
			o_ym_q      <= ymean_q;
			o_xs_q      <= xsd_q;
			o_ys_q      <= ysd_q;
		end
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			axis_q   <= 1'b0;
			run_q    <= 1'b0;
			done_q   <= 1'b0;
			ovalid_q <= 1'b0;
			avg_q    <= 10'd10;
			scnt_q   <= '0;
			xcnt_q   <= '0;
			ycnt_q   <= '0;
			xbad_q   <= '0;
			ybad_q   <= '0;
			xsum_q   <= '0;
			ysum_q   <= '0;
			xsq_q    <= '0;
			ysq_q    <= '0;
			xmean_q  <= '0;
			ymean_q  <= '0;
			xsd_q    <= '0;
			ysd_q    <= '0;
		end else begin
			if (load_out)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q  <= 1'b0;
						state_q <= S_DONE;
						if (item.cmd == tamsa_pkg::CMD_START) begin
							run_q  <= 1'b1;
							scnt_q <= '0;
							xcnt_q <= '0;
							ycnt_q <= '0;
							xbad_q <= '0;
							ybad_q <= '0;
							xsum_q <= '0;
							ysum_q <= '0;
							xsq_q  <= '0;
							ysq_q  <= '0;
						end else if (item.cmd == tamsa_pkg::CMD_STOP) begin
							run_q <= 1'b0;
						end else if (item.cmd == tamsa_pkg::CMD_SAMPLE && run_q) begin
							// Counts and plain sums settle now; squares follow
							// through the multiplier.
							scnt_q <= sat_inc(scnt_q);
							if (xvalid) begin
								xcnt_q <= sat_inc(xcnt_q);
								xsum_q <= xsum_q + {{9{xs[22]}}, xs};
							end else begin
								xbad_q <= sat_inc(xbad_q);
							end
							if (yvalid) begin
								ycnt_q <= sat_inc(ycnt_q);
								ysum_q <= ysum_q + {{9{ys[22]}}, ys};
							end else begin
								ybad_q <= sat_inc(ybad_q);
							end
							state_q <= S_SQX;
						end
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					if (xv_q)
						xsq_q <= xsq_q + prod_q[tamsa_pkg::SQ_W-1:0];
					state_q <= S_END;
				end
				S_END: begin
					if (yv_q)
						ysq_q <= ysq_q + prod_q[tamsa_pkg::SQ_W-1:0];
					state_q <= S_DONE;
					if (scnt_q >= avg_q) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
						// A zero run length ends the run but keeps the held results.
						if (avg_q != '0) begin
							axis_q  <= 1'b0;
							state_q <= S_DEN;
						end
					end
				end
				S_DEN: begin
					if (n == '0) begin
						// An axis without valid samples reports zero.
						if (axis_q) begin
							ymean_q <= '0;
							ysd_q   <= '0;
							state_q <= S_DONE;
						end else begin
							xmean_q <= '0;
							xsd_q   <= '0;
							axis_q  <= 1'b1;
						end
					end else begin
						state_q <= S_MEANM;
					end
				end
				S_MEANM: state_q <= S_MEANA;
				S_MEANA: state_q <= S_MDIV;
				S_MDIV:  state_q <= S_MWAIT;
				S_MWAIT: begin
					if (ursp.done) begin
						if (axis_q)
							ymean_q <= mean_sat;
						else
							xmean_q <= mean_sat;
						state_q <= S_D1L;
					end
				end
				S_D1L: state_q <= S_D1H;
				S_D1H: state_q <= S_D2;
				S_D2:  state_q <= S_SUB;
				S_SUB: state_q <= S_SQRT;
				S_SQRT: state_q <= S_QWAIT;
				S_QWAIT: begin
					if (ursp.done)
						state_q <= S_SDA;
				end
				S_SDA:  state_q <= S_SDIV;
				S_SDIV: state_q <= S_SWAIT;
				// Final wait of the standard deviation division; the x axis hands
				// over to the y axis, the y axis finishes the request.
				S_SWAIT: begin
					if (ursp.done) begin
						if (axis_q) begin
							ysd_q   <= sd_sat;
							state_q <= S_DONE;
						end else begin
							xsd_q   <= sd_sat;
							axis_q  <= 1'b1;
							state_q <= S_DEN;
						end
					end
				end
				S_DONE: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// A configuration write restarts the sums and the sample count. It is
			// only taken while idle and never together with a request.
			if (cfg.valid && cfg.ready) begin
				avg_q  <= cfg.average_size;
				scnt_q <= '0;
				xsum_q <= '0;
				ysum_q <= '0;
				xsq_q  <= '0;
				ysq_q  <= '0;
			end
		end
	end

	assign item.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready  = (state_q == S_IDLE);

	assign result.valid           = ovalid_q;
	assign result.running         = o_running_q;
	assign result.done_res        = o_done_q;
	assign result.x_valid_count   = o_xc_q;
	assign result.y_valid_count   = o_yc_q;
	assign result.x_invalid_count = o_xb_q;
	assign result.y_invalid_count = o_yb_q;
	assign result.x_mean          = o_xm_q;
	assign result.y_mean          = o_ym_q;
	assign result.x_stddev        = o_xs_q;
	assign result.y_stddev        = o_ys_q;

	`TAMSA_ASSERT(a_done_stops_run, clk, arst_n, result.valid && result.done_res |-> !result.running)
	`TAMSA_ASSERT(a_one_request, clk, arst_n, (item.valid && item.ready) |=> !item.ready)
	`TAMSA_NEVER(a_cnt_sat, clk, arst_n, (xcnt_q > CNT_LIM) || (ycnt_q > CNT_LIM) || (scnt_q > CNT_LIM))
endmodule
`default_nettype wire
